[hw/rtl/dual_wheel_pid_speed_control_core_assert.svh]
// assertion macros shared by the speed control core
`ifndef DUAL_WHEEL_PID_SPEED_CONTROL_CORE_ASSERT_SVH
`define DUAL_WHEEL_PID_SPEED_CONTROL_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DWPID_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("dwpid check failed");
`define DWPID_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("dwpid implication failed");
`else
`define DWPID_ASSERT(lbl, clk, rstn, prop)
`define DWPID_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/dwpid_pkg.sv]
`default_nettype none
package dwpid_pkg;

	// one control tick
	typedef struct packed {
		logic signed [15:0] count_left;
		logic signed [15:0] count_right_raw;
		logic signed [15:0] target_left;
		logic signed [15:0] target_right;
	} meas_item_t;

	// one motor drive result
	typedef struct packed {
		logic [6:0] duty_left;
		logic [6:0] duty_right;
		logic       reversing;
	} drive_item_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_GAIN_PROP     = 2'd0,
		CFG_GAIN_INTEGRAL = 2'd1,
		CFG_GAIN_DERIV    = 2'd2,
		CFG_REVERSE_SPEED = 2'd3
	} cfg_index_t;

	// Q8.8 gains as seen by the lanes
	typedef struct packed {
		logic [15:0] kp;
		logic [15:0] ki;
		logic [15:0] kd;
	} gains_t;

	// stage load strobes handed to the lanes and the merge stage
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

	localparam int STALL_SPEED_MAX   = 25;
	localparam int STALL_TICKS_LIMIT = 40;
	localparam int STALL_TICKS_TOP   = 127;
	localparam int REVERSE_RELOAD    = 50;
	localparam int DUTY_MID          = 50;
	localparam int DUTY_MIN          = 5;
	localparam int DUTY_MAX          = 95;
	localparam int NUM_STAGES        = 6;

endpackage
`default_nettype wire

[hw/rtl/dwpid_front.sv]
`default_nettype none
`include "dual_wheel_pid_speed_control_core_assert.svh"
module dwpid_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  dwpid_pkg::meas_item_t meas_item,
	input  logic [14:0]          reverse_speed,
	output logic signed [16:0]   err_left_s1,
	output logic signed [16:0]   err_right_s1,
	output logic                 rev_s1
);
	import dwpid_pkg::*;

	logic [6:0]         stall_q;
	logic [5:0]         reverse_q;
	logic [6:0]         stall_d;
	logic [5:0]         reverse_d;
	logic signed [16:0] speed_l;
	logic signed [16:0] speed_r;
	logic signed [16:0] tgt_l;
	logic signed [16:0] tgt_r;
	logic signed [17:0] diff_l;
	logic signed [17:0] diff_r;
	logic               rev_active;
	logic               slow;

	// wheel speeds and targets, reverse recovery overrides the targets
	always_comb begin
		speed_l    = {meas_item.count_left[15], meas_item.count_left};
		speed_r    = -{meas_item.count_right_raw[15], meas_item.count_right_raw};
		rev_active = (reverse_q != '0);
		if (rev_active) begin
			tgt_l = -$signed({2'b00, reverse_speed});
			tgt_r = -$signed({2'b00, reverse_speed});
		end else begin
			tgt_l = {meas_item.target_left[15], meas_item.target_left};
			tgt_r = {meas_item.target_right[15], meas_item.target_right};
		end
		diff_l = {tgt_l[16], tgt_l} - {speed_l[16], speed_l};
		diff_r = {tgt_r[16], tgt_r} - {speed_r[16], speed_r};
	end

	// stall detection and countdown reload
	always_comb begin
		slow = (speed_l <= STALL_SPEED_MAX && speed_l >= -STALL_SPEED_MAX) ||
		       (speed_r <= STALL_SPEED_MAX && speed_r >= -STALL_SPEED_MAX);
		if (slow) begin
			if (stall_q == 7'(STALL_TICKS_TOP)) begin
				stall_d = stall_q;
			end else begin
				stall_d = stall_q + 7'd1;
			end
		end else begin
			stall_d = '0;
		end
		if (rev_active) begin
			reverse_d = reverse_q - 6'd1;
		end else begin
			reverse_d = reverse_q;
		end
		if (stall_d > 7'(STALL_TICKS_LIMIT)) begin
			reverse_d = 6'(REVERSE_RELOAD);
		end
	end

	// recovery state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_q   <= '0;
			reverse_q <= '0;
		end else if (accept) begin
			stall_q   <= stall_d;
			reverse_q <= reverse_d;
		end
	end

	// stage 1 errors
	always_ff @(posedge clk) begin
		if (accept) begin
			err_left_s1  <= diff_l[16:0];
			err_right_s1 <= diff_r[16:0];
			rev_s1       <= (reverse_d != '0);
		end
	end

	`DWPID_ASSERT_IMP(a_stall_reload, clk, arst_n, stall_q > 7'(STALL_TICKS_LIMIT), reverse_q == 6'(REVERSE_RELOAD))

endmodule
`default_nettype wire

[hw/rtl/dwpid_lane.sv]
`default_nettype none
`include "dual_wheel_pid_speed_control_core_assert.svh"
module dwpid_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dwpid_pkg::stage_en_t  en,
	input  dwpid_pkg::gains_t     gains,
	input  logic signed [16:0]    err_s1,
	output logic [6:0]            duty
);
	import dwpid_pkg::*;

	logic signed [31:0] sum_q;
	logic signed [16:0] prev_q;
	logic               seen_q;
	logic signed [39:0] acc_q;
	logic signed [16:0] err_s2;
	logic signed [17:0] diff_s2;
	logic signed [33:0] prod_p_s3;
	logic signed [48:0] prod_i_s3;
	logic signed [34:0] prod_d_s3;
	logic signed [49:0] inc_s4;

	logic signed [32:0] sum_wide;
	logic signed [31:0] sum_d;
	logic signed [17:0] diff_d;
	logic signed [49:0] inc_d;
	logic signed [50:0] acc_wide;
	logic signed [39:0] acc_d;
	logic signed [31:0] whole;

	// stage 2: saturating error sum and error difference
	always_comb begin
		sum_wide = {sum_q[31], sum_q} + {{16{err_s1[16]}}, err_s1};
		if (sum_wide[32] != sum_wide[31]) begin
			sum_d = sum_wide[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end else begin
			sum_d = sum_wide[31:0];
		end
		if (seen_q) begin
			diff_d = {err_s1[16], err_s1} - {prev_q[16], prev_q};
		end else begin
			diff_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			prev_q <= '0;
			seen_q <= 1'b0;
		end else if (en.s2) begin
			sum_q  <= sum_d;
			prev_q <= err_s1;
			seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			err_s2  <= err_s1;
			diff_s2 <= diff_d;
		end
	end

	// stage 3: gain products, one multiplier per term
	always_ff @(posedge clk) begin
		if (en.s3) begin
			prod_p_s3 <= $signed({1'b0, gains.kp}) * err_s2;
			prod_i_s3 <= $signed({1'b0, gains.ki}) * sum_q;
			prod_d_s3 <= $signed({1'b0, gains.kd}) * diff_s2;
		end
	end

	// stage 4: exact sum of the three terms
	always_comb begin
		inc_d = {{16{prod_p_s3[33]}}, prod_p_s3} + {prod_i_s3[48], prod_i_s3} +
		        {{15{prod_d_s3[34]}}, prod_d_s3};
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			inc_s4 <= inc_d;
		end
	end

	// stage 5: saturating accumulator
	always_comb begin
		acc_wide = {{11{acc_q[39]}}, acc_q} + {inc_s4[49], inc_s4};
		if (acc_wide[50:39] != {12{acc_wide[39]}}) begin
			acc_d = acc_wide[50] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
		end else begin
			acc_d = acc_wide[39:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (en.s5) begin
			acc_q <= acc_d;
		end
	end

	// duty from the integer part, clamped
	always_comb begin
		whole = acc_q[39:8];
		if (whole < (DUTY_MIN - DUTY_MID)) begin
			duty = 7'(DUTY_MIN);
		end else if (whole > (DUTY_MAX - DUTY_MID)) begin
			duty = 7'(DUTY_MAX);
		end else begin
			duty = 7'(whole + DUTY_MID);
		end
	end

	`DWPID_ASSERT_IMP(a_first_clean, clk, arst_n, !seen_q, sum_q == '0 && prev_q == '0)

endmodule
`default_nettype wire

[hw/rtl/dwpid_merge.sv]
`default_nettype none
module dwpid_merge (
	input  logic                   clk,
	input  dwpid_pkg::stage_en_t   en,
	input  logic                   rev_s1,
	input  logic [6:0]             duty_left,
	input  logic [6:0]             duty_right,
	output dwpid_pkg::drive_item_t drive_item_s6
);
	import dwpid_pkg::*;

	logic rev_s2;
	logic rev_s3;
	logic rev_s4;
	logic rev_s5;

	// recovery flag follows the lanes down the pipe
	always_ff @(posedge clk) begin
		if (en.s2) begin
			rev_s2 <= rev_s1;
		end
		if (en.s3) begin
			rev_s3 <= rev_s2;
		end
		if (en.s4) begin
			rev_s4 <= rev_s3;
		end
		if (en.s5) begin
			rev_s5 <= rev_s4;
		end
	end

	// result register joins both lanes and the flag
	always_ff @(posedge clk) begin
		if (en.s6) begin
			drive_item_s6.duty_left  <= duty_left;
			drive_item_s6.duty_right <= duty_right;
			drive_item_s6.reversing  <= rev_s5;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/dual_wheel_pid_speed_control_core.sv]
// channel | direction | handshake             | payload
// meas    | in        | meas_valid/meas_stall | meas_item (counts, targets)
// drive   | out       | drive_valid/drive_stall | drive_item (duties, reversing)
// cfg     | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// one item per cycle sustained while drive_stall is low; a result is valid once its item
// has passed the six-stage pipe (errors, sum, products, add, accumulate, duty)
// async reset clears pipe valids, gains, sums, accumulators and counters
// a stalled result holds in the output stage; empty stages keep filling
// meas_stall rises only with all six stages full and drive_stall high
`default_nettype none
`include "dual_wheel_pid_speed_control_core_assert.svh"
module dual_wheel_pid_speed_control_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   meas_valid,
	output logic                   meas_stall,
	input  dwpid_pkg::meas_item_t  meas_item,
	output logic                   drive_valid,
	input  logic                   drive_stall,
	output dwpid_pkg::drive_item_t drive_item,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  dwpid_pkg::cfg_index_t  cfg_index,
	input  logic [15:0]            cfg_data
);
	import dwpid_pkg::*;

	logic [NUM_STAGES:1]   valid_q;
	logic [NUM_STAGES+1:1] rdy;
	logic [NUM_STAGES:1]   upv;
	logic [NUM_STAGES:1]   load;
	stage_en_t             en;
	gains_t                gains_q;
	logic [14:0]           reverse_speed_q;
	logic signed [16:0]    err_left_s1;
	logic signed [16:0]    err_right_s1;
	logic                  rev_s1;
	logic [6:0]            duty_left;
	logic [6:0]            duty_right;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q         <= '0;
			reverse_speed_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GAIN_PROP:     gains_q.kp      <= cfg_data;
				CFG_GAIN_INTEGRAL: gains_q.ki      <= cfg_data;
				CFG_GAIN_DERIV:    gains_q.kd      <= cfg_data;
				CFG_REVERSE_SPEED: reverse_speed_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// stage advance: a stage takes a new item when empty or draining
	always_comb begin
		rdy[NUM_STAGES+1] = !drive_stall;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
		upv  = {valid_q[NUM_STAGES-1:1], meas_valid};
		load = rdy[NUM_STAGES:1] & upv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (rdy[NUM_STAGES:1] & upv) | (~rdy[NUM_STAGES:1] & valid_q);
		end
	end

	assign en = '{s2: load[2], s3: load[3], s4: load[4], s5: load[5], s6: load[6]};

	assign meas_stall  = !rdy[1];
	assign drive_valid = valid_q[NUM_STAGES];

	// stage 1: speeds, recovery and errors
	dwpid_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (load[1]),
		.meas_item    (meas_item),
		.reverse_speed(reverse_speed_q),
		.err_left_s1  (err_left_s1),
		.err_right_s1 (err_right_s1),
		.rev_s1       (rev_s1)
	);

	// one PID lane per wheel
	dwpid_lane u_lane_left (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.gains (gains_q),
		.err_s1(err_left_s1),
		.duty  (duty_left)
	);

	dwpid_lane u_lane_right (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.gains (gains_q),
		.err_s1(err_right_s1),
		.duty  (duty_right)
	);

	// merge lanes into the result register
	dwpid_merge u_merge (
		.clk          (clk),
		.en           (en),
		.rev_s1       (rev_s1),
		.duty_left    (duty_left),
		.duty_right   (duty_right),
		.drive_item_s6(drive_item)
	);

	`DWPID_ASSERT_IMP(a_stall_only_full, clk, arst_n, meas_stall, &valid_q)
	`DWPID_ASSERT_IMP(a_duty_range, clk, arst_n, drive_valid, drive_item.duty_left >= 7'(DUTY_MIN) && drive_item.duty_left <= 7'(DUTY_MAX) && drive_item.duty_right >= 7'(DUTY_MIN) && drive_item.duty_right <= 7'(DUTY_MAX))
	`DWPID_ASSERT(a_held_result, clk, arst_n, (drive_valid && drive_stall) |=> drive_valid)

endmodule
`default_nettype wire

[tb/tb_dual_wheel_pid_speed_control_core.sv]
`timescale 1ns / 1ps
module tb_dual_wheel_pid_speed_control_core;
	import dwpid_pkg::*;

	localparam int    LIMIT_CYCLES  = 1000000;
	localparam int    DRAIN_CYCLES  = 16;
	localparam int    RESET_ROWS    = 8;
	localparam int    SLOW_SPEED    = 25;
	localparam int    STALL_TRIP    = 40;
	localparam int    STALL_TOP     = 127;
	localparam int    REVERSE_TICKS = 50;
	localparam int    DUTY_CENTER   = 50;
	localparam int    DUTY_FLOOR    = 5;
	localparam int    DUTY_CEIL     = 95;
	localparam longint SUM_MAX      = 64'sd2147483647;
	localparam longint SUM_MIN      = -SUM_MAX - 1;
	localparam longint ACC_MAX      = (64'sd1 <<< 39) - 1;
	localparam longint ACC_MIN      = -ACC_MAX - 1;

	// receiver stall patterns
	typedef enum int {PACE_FREE, PACE_RANDOM, PACE_PERIODIC, PACE_BURST} pace_t;

	typedef struct {
		meas_item_t  tick;
		bit          known;
		drive_item_t want;
	} script_row_t;

	typedef struct packed {
		bit          known;
		drive_item_t want;
	} preset_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        meas_valid = 1'b0;
	logic        meas_stall;
	meas_item_t  meas_item = '0;
	logic        drive_valid;
	logic        drive_stall = 1'b0;
	drive_item_t drive_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_index_t  cfg_index = CFG_GAIN_PROP;
	logic [15:0] cfg_data = '0;

	// predictor state and settings
	longint kp, ki, kd, rev_speed;
	longint err_sum [2];
	longint prev_err [2];
	longint drive_acc [2];
	bit     seen_err [2];
	int     stall_cnt, rev_cnt;

	script_row_t script [$];
	preset_t     preset_q [$];
	drive_item_t expected_drive [$];

	pace_t  pace = PACE_FREE;
	int     pace_run = 0;
	bit     sender_gaps = 1'b0;
	int     burst_left = 0;
	int     cyc = 0;
	int     n_sent = 0, n_checked = 0, n_fail = 0;
	int     n_directed = 0, n_random = 0;
	int     n_rev = 0, n_clamped = 0, n_stall_top = 0, n_sum_sat = 0, n_acc_sat = 0;
	int     brink_vals [8] = '{-32768, 32767, -26, -25, 25, 26, 24, -24};

	dual_wheel_pid_speed_control_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.meas_valid  (meas_valid),
		.meas_stall  (meas_stall),
		.meas_item   (meas_item),
		.drive_valid (drive_valid),
		.drive_stall (drive_stall),
		.drive_item  (drive_item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run watchdog
	always @(posedge clk) begin
		cyc++;
		if (cyc > LIMIT_CYCLES) begin
			$display("watchdog expired after %0d cycles, %0d of %0d drive items seen",
				cyc, n_checked, n_sent);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		case (pace)
		PACE_FREE: begin
			drive_stall <= 1'b0;
		end
		PACE_RANDOM: begin
			drive_stall <= ($urandom_range(0, 99) < 35);
		end
		PACE_PERIODIC: begin
			pace_run <= (pace_run + 1) % 9;
			drive_stall <= (pace_run >= 5);
		end
		default: begin
			if (pace_run <= 0) begin
				drive_stall <= !drive_stall;
				pace_run <= $urandom_range(1, 16);
			end else begin
				pace_run <= pace_run - 1;
			end
		end
		endcase
	end

	// one wheel of the incremental pid, returns the clamped duty
	function automatic logic [6:0] wheel_duty(input int w, input longint err);
		longint s, d, a, whole;
		s = err_sum[w] + err;
		if (s > SUM_MAX || s < SUM_MIN) n_sum_sat++;
		if (s > SUM_MAX) s = SUM_MAX;
		if (s < SUM_MIN) s = SUM_MIN;
		err_sum[w] = s;
		d = seen_err[w] ? err - prev_err[w] : 0;
		prev_err[w] = err;
		seen_err[w] = 1'b1;
		a = drive_acc[w] + kp * err + ki * s + kd * d;
		if (a > ACC_MAX || a < ACC_MIN) n_acc_sat++;
		if (a > ACC_MAX) a = ACC_MAX;
		if (a < ACC_MIN) a = ACC_MIN;
		drive_acc[w] = a;
		// arithmetic shift gives the floor of the fixed point value
		whole = DUTY_CENTER + (a >>> 8);
		if (whole < DUTY_FLOOR) whole = DUTY_FLOOR;
		if (whole > DUTY_CEIL) whole = DUTY_CEIL;
		return 7'(whole);
	endfunction

	function automatic longint magnitude(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// expected drive item for one control tick
	function automatic drive_item_t next_drive(input meas_item_t m);
		longint spd_l, spd_r, tgt_l, tgt_r;
		drive_item_t r;
		spd_l = longint'($signed(m.count_left));
		spd_r = -longint'($signed(m.count_right_raw));
		tgt_l = longint'($signed(m.target_left));
		tgt_r = longint'($signed(m.target_right));
		// stall recovery overrides both targets
		if (rev_cnt != 0) begin
			tgt_l = -rev_speed;
			tgt_r = -rev_speed;
			rev_cnt--;
		end
		if (magnitude(spd_l) <= SLOW_SPEED || magnitude(spd_r) <= SLOW_SPEED) begin
			if (stall_cnt < STALL_TOP) stall_cnt++;
			else n_stall_top++;
		end else begin
			stall_cnt = 0;
		end
		if (stall_cnt > STALL_TRIP) rev_cnt = REVERSE_TICKS;
		r.duty_left = wheel_duty(0, tgt_l - spd_l);
		r.duty_right = wheel_duty(1, tgt_r - spd_r);
		r.reversing = (rev_cnt != 0);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		n_fail++;
		if (n_fail <= 40)
			$display("[%0t] drive item %0d: %s got %0d want %0d", $time, n_checked, what,
				got, want);
	endtask

	// accepted ticks feed the predictor
	always @(posedge clk) begin : meas_mon
		preset_t     pre;
		drive_item_t pred;
		if (arst_n && meas_valid && !meas_stall) begin
			pre = preset_q.pop_front();
			pred = next_drive(meas_item);
			expected_drive.push_back(pre.known ? pre.want : pred);
		end
	end

	// accepted drive items against the oldest expectation
	always @(posedge clk) begin : drive_mon
		drive_item_t want;
		if (arst_n && drive_valid && !drive_stall) begin
			if (expected_drive.size() == 0) begin
				report_mismatch("unexpected item, duty_left", drive_item.duty_left, 0);
			end else begin
				want = expected_drive.pop_front();
				if (drive_item.duty_left !== want.duty_left)
					report_mismatch("duty_left", drive_item.duty_left, want.duty_left);
				if (drive_item.duty_right !== want.duty_right)
					report_mismatch("duty_right", drive_item.duty_right, want.duty_right);
				if (drive_item.reversing !== want.reversing)
					report_mismatch("reversing", drive_item.reversing, want.reversing);
				if (want.reversing) n_rev++;
				if (want.duty_left == DUTY_FLOOR || want.duty_left == DUTY_CEIL) n_clamped++;
				n_checked++;
			end
		end
	end

	function automatic void add_row(input int cl, input int cr, input int tl, input int tr,
			input bit known);
		script_row_t row;
		row.tick = '{16'(cl), 16'(cr), 16'(tl), 16'(tr)};
		row.known = known;
		row.want = '{7'(DUTY_CENTER), 7'(DUTY_CENTER), 1'b0};
		script.push_back(row);
	endfunction

	function automatic logic signed [15:0] clamp16(input int v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return 16'(v);
	endfunction

	function automatic int rand_span(input int n);
		return int'($urandom_range(0, 2 * n)) - n;
	endfunction

	// nudge the error so the accumulator tends back toward mid duty
	function automatic int steer(input int w);
		int pull;
		pull = int'($urandom_range(0, 30));
		return (drive_acc[w] > 0 ? pull : -pull) + rand_span(10);
	endfunction

	task automatic send_tick(input meas_item_t tick, input bit known, input drive_item_t want);
		preset_q.push_back('{known, want});
		meas_item <= tick;
		meas_valid <= 1'b1;
		@(posedge clk);
		while (meas_stall) @(posedge clk);
		n_sent++;
		if (sender_gaps) begin
			if (burst_left <= 0) begin
				meas_valid <= 1'b0;
				burst_left = $urandom_range(1, 20);
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// sender holds off until every expected item has come back
	task automatic wait_drained();
		meas_valid <= 1'b0;
		while (n_checked < n_sent) @(posedge clk);
	endtask

	task automatic load_settings(input logic [15:0] p, input logic [15:0] i,
			input logic [15:0] d, input logic [15:0] rs);
		cfg_index_t  idx [4];
		logic [15:0] val [4];
		idx = '{CFG_GAIN_PROP, CFG_GAIN_INTEGRAL, CFG_GAIN_DERIV, CFG_REVERSE_SPEED};
		val = '{p, i, d, rs};
		for (int n = 0; n < 4; n++) begin
			cfg_index <= idx[n];
			cfg_data <= val[n];
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			case (idx[n])
			CFG_GAIN_PROP:     kp = longint'(val[n]);
			CFG_GAIN_INTEGRAL: ki = longint'(val[n]);
			CFG_GAIN_DERIV:    kd = longint'(val[n]);
			CFG_REVERSE_SPEED: rev_speed = longint'(val[n][14:0]);
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic walk_script(input int lo, input int hi);
		for (int n = lo; n < hi; n++)
			send_tick(script[n].tick, script[n].known, script[n].want);
	endtask

	// random segments: cruising, stalls long enough to trip recovery, brinks and noise
	task automatic run_random(input int n_items);
		int         done, kind, seg_len, sl, sr, tl, tr;
		meas_item_t m;
		done = 0;
		while (done < n_items) begin
			kind = $urandom_range(0, 9);
			if (kind <= 3) seg_len = $urandom_range(5, 40);
			else if (kind <= 5) seg_len = ($urandom_range(0, 3) == 0) ?
				$urandom_range(128, 150) : $urandom_range(20, 60);
			else if (kind <= 7) seg_len = $urandom_range(1, 8);
			else seg_len = $urandom_range(1, 6);
			for (int k = 0; k < seg_len && done < n_items; k++) begin
				tl = rand_span(3000);
				tr = rand_span(3000);
				sl = tl + steer(0);
				sr = tr + steer(1);
				if (kind == 4 || kind == 5) begin
					if (kind == 4 || $urandom_range(0, 1) == 0) sl = rand_span(SLOW_SPEED);
					if (kind == 5 || $urandom_range(0, 2) == 0) sr = rand_span(SLOW_SPEED);
				end else if (kind >= 8) begin
					sl = brink_vals[$urandom_range(0, 7)];
					sr = brink_vals[$urandom_range(0, 7)];
					tl = rand_span(32767);
					tr = rand_span(32767);
				end
				m.count_left = clamp16(sl);
				m.count_right_raw = clamp16(-sr);
				m.target_left = clamp16(tl);
				m.target_right = clamp16(tr);
				if (kind == 6 || kind == 7) m = meas_item_t'({$urandom(), $urandom()});
				send_tick(m, 1'b0, '0);
				done++;
			end
		end
	endtask

	// runs of full scale error at top gains drive the accumulators into saturation
	task automatic soak_saturation(input int n_up, input int n_down);
		meas_item_t up, down;
		up = '{-16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767};
		down = '{16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768};
		for (int n = 0; n < n_up; n++) send_tick(up, 1'b0, '0);
		for (int n = 0; n < n_down; n++) send_tick(down, 1'b0, '0);
	endtask

	initial begin : main
		kp = 0; ki = 0; kd = 0; rev_speed = 0;
		err_sum = '{0, 0}; prev_err = '{0, 0}; drive_acc = '{0, 0}; seen_err = '{0, 0};
		stall_cnt = 0; rev_cnt = 0;

		// zero gains after reset hold the duty at center
		add_row(0, 0, 0, 0, 1'b1);
		add_row(32767, -32768, 32767, -32768, 1'b1);
		add_row(-32768, 32767, -32768, 32767, 1'b1);
		add_row(-1, -1, -1, -1, 1'b1);
		add_row(25, -25, 25, -25, 1'b1);
		add_row(26, -26, -26, 26, 1'b1);
		add_row(-26, 26, 0, 0, 1'b1);
		add_row(21845, -21846, -21846, 21845, 1'b1);
		// full scale errors both ways, biggest differences, stall speed brinks
		add_row(0, 0, 0, 0, 1'b0);
		add_row(-32768, 32767, 32767, 32767, 1'b0);
		add_row(32767, -32768, -32768, -32768, 1'b0);
		add_row(-32768, 32767, 32767, 32767, 1'b0);
		add_row(32767, -32768, -32768, -32768, 1'b0);
		add_row(25, -26, 25, -26, 1'b0);
		add_row(-25, 26, -25, 26, 1'b0);
		add_row(26, -26, 26, -26, 1'b0);
		add_row(-26, 25, 0, 0, 1'b0);
		add_row(100, -100, 120, -80, 1'b0);
		add_row(100, -100, 100, -100, 1'b0);
		add_row(0, 0, -32768, 32767, 1'b0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		pace = PACE_RANDOM;
		sender_gaps = 1'b1;
		walk_script(0, RESET_ROWS);
		wait_drained();
		load_settings(16'h0100, 16'h0004, 16'h0080, 16'h8064);
		walk_script(RESET_ROWS, script.size());
		wait_drained();
		n_directed = n_sent;

		// random part over several settings
		load_settings(16'h0020, 16'h0001, 16'h0010, 16'd300);
		run_random(140);
		wait_drained();
		run_random(135);
		wait_drained();

		load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
		pace = PACE_FREE;
		sender_gaps = 1'b0;
		run_random(275);
		wait_drained();

		load_settings(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
		pace = PACE_PERIODIC;
		sender_gaps = 1'b1;
		run_random(275);
		wait_drained();

		load_settings(16'h0000, 16'h0002, 16'h0000, 16'h0000);
		pace = PACE_BURST;
		run_random(150);
		wait_drained();
		n_random = n_sent - n_directed;

		// saturation soak at full rate
		load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		pace = PACE_FREE;
		sender_gaps = 1'b0;
		soak_saturation(40, 80);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_drive.size() != 0)
			report_mismatch("expected items left over", expected_drive.size(), 0);
		$display("ticks: %0d directed, %0d random, %0d soak; %0d drive items checked",
			n_directed, n_random, n_sent - n_directed - n_random, n_checked);
		$display("reversing %0d, clamped left duty %0d, stall count held %0d, sum sat %0d, acc sat %0d",
			n_rev, n_clamped, n_stall_top, n_sum_sat, n_acc_sat);
		if (n_fail == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/dwpid_pkg.sv
hw/rtl/dwpid_front.sv
hw/rtl/dwpid_lane.sv
hw/rtl/dwpid_merge.sv
hw/rtl/dual_wheel_pid_speed_control_core.sv
tb/tb_dual_wheel_pid_speed_control_core.sv
